// ===== design/ffba_pkg.sv =====
// shared types and codes for the first fit block allocator
// no dependencies
package ffba_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_TOK_START,
    OP_TOK_RIGHT,
    OP_ALLOC_WHOLE,
    OP_ALLOC_SPLIT,
    OP_ABSORB_RIGHT,
    OP_ABSORB_LEFT,
    OP_RELEASE
  } cell_op_t;

  typedef struct packed {
    logic tok;
    logic fit;
    logic split_ok;
    logic free_hit;
    logic valid;
    logic r_free;
    logic l_free;
  } cell_flags_t;

endpackage

// ===== design/ffba_cell.sv =====
// one table entry of the allocator chain, with scan token and neighbor shifts
// depends on ffba_pkg
module ffba_cell import ffba_pkg::*; #(
  parameter int ARENA_BYTES  = 16384,
  parameter int HEADER_BYTES = 32,
  parameter int IDX          = 0,
  localparam int SW = $clog2(ARENA_BYTES),
  localparam int LW = $clog2(ARENA_BYTES + 1),
  localparam int AW = ((LW > 15) ? LW : 15) + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_op_t      op,
  input  logic [AW-1:0] size,
  input  logic [AW-1:0] offset,
  input  logic [SW-1:0] l_start,
  input  logic [LW-1:0] l_len,
  input  logic          l_used,
  input  logic          l_valid,
  input  logic          l_tok,
  input  logic [SW-1:0] r_start,
  input  logic [LW-1:0] r_len,
  input  logic          r_used,
  input  logic          r_valid,
  input  logic          r_tok,
  output logic [SW-1:0] start,
  output logic [LW-1:0] len,
  output logic          used,
  output logic          valid,
  output logic          tok,
  output cell_flags_t   flags
);

  localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

  logic          ahead;
  logic [AW-1:0] need;
  logic [AW-1:0] rem_start;
  logic [AW-1:0] rem_len;
  logic [AW-1:0] own_span;
  logic [AW-1:0] right_span;

  assign need       = size + HDR;
  assign rem_start  = AW'(l_start) + size + HDR;
  assign rem_len    = AW'(l_len) - HDR - size;
  assign right_span = AW'(r_start) + AW'(r_len) - AW'(start);
  assign own_span   = right_span;

  assign flags.tok      = tok;
  assign flags.valid    = tok & valid;
  assign flags.fit      = tok & valid & ~used & (AW'(len) > need);
  assign flags.split_ok = tok & (AW'(len) > need + HDR);
  assign flags.free_hit = tok & valid & used & (AW'(start) == offset);
  assign flags.r_free   = tok & r_valid & ~r_used;
  assign flags.l_free   = tok & l_valid & ~l_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= (IDX == 0);
      used  <= 1'b0;
      tok   <= 1'b0;
      ahead <= 1'b0;
      start <= (IDX == 0) ? SW'(HEADER_BYTES) : '0;
      len   <= (IDX == 0) ? LW'(ARENA_BYTES - HEADER_BYTES) : '0;
    end else begin
      unique case (op)
        OP_HOLD: begin
        end
        OP_TOK_START: begin
          tok   <= (IDX == 0);
          ahead <= (IDX != 0);
        end
        OP_TOK_RIGHT: begin
          tok   <= l_tok;
          ahead <= ahead & ~l_tok;
        end
        OP_ALLOC_WHOLE: begin
          if (tok) used <= 1'b1;
        end
        OP_ALLOC_SPLIT: begin
          if (tok) begin
            len  <= LW'(size);
            used <= 1'b1;
          end else if (l_tok) begin
            start <= SW'(rem_start);
            len   <= LW'(rem_len);
            used  <= 1'b0;
            valid <= 1'b1;
          end else if (ahead) begin
            start <= l_start;
            len   <= l_len;
            used  <= l_used;
            valid <= l_valid;
          end
        end
        OP_ABSORB_RIGHT: begin
          if (tok) begin
            len <= LW'(own_span);
          end else if (ahead) begin
            start <= r_start;
            len   <= r_len;
            used  <= r_used;
            valid <= r_valid;
          end
        end
        OP_ABSORB_LEFT: begin
          if (r_tok) begin
            len   <= LW'(right_span);
            tok   <= 1'b1;
            ahead <= 1'b0;
          end else if (tok | ahead) begin
            start <= r_start;
            len   <= r_len;
            used  <= r_used;
            valid <= r_valid;
            tok   <= 1'b0;
            ahead <= 1'b1;
          end
        end
        OP_RELEASE: begin
          if (tok) used <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/first_fit_block_allocator_unit.sv =====
// first fit block allocator top level: command handshake, sequencer, cell chain
// depends on ffba_pkg and ffba_cell
//
// usage: drive command, request_size and block_offset with start high; the item
// is taken at an edge where start is high and busy is low. busy stays high
// while the item is worked on. exactly one result per item appears on
// payload_offset and status for one cycle with done high; the receiver cannot
// stall, so it must take the result in that cycle.
// scan: an allocate scans the chain one entry per cycle, from the first entry up
// to the chosen entry, or to the end of the valid entries on no fit. a free scans
// the same way to the used entry at the offset, then merges free right neighbors
// and then free left neighbors; an unknown offset ends like a no fit. the
// walking token in the cell chain marks the entry in work; splits and merges
// shift the entries behind it by one entry.
// a new item may be started in the cycle done is high.
// reset: synchronous, holds one free block spanning the arena, no item in work.
module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int ARENA_BYTES  = 16384,
  parameter int HEADER_BYTES = 32,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [14:0] request_size,
  input  logic [13:0] block_offset,
  output logic        done,
  output logic [13:0] payload_offset,
  output logic [1:0]  status
);

  localparam int SW    = $clog2(ARENA_BYTES);
  localparam int LW    = $clog2(ARENA_BYTES + 1);
  localparam int AW    = ((LW > 15) ? LW : 15) + 2;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_MERGE_R = 4'b0100,
    S_MERGE_L = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic             cmd;
  logic [AW-1:0]    size;
  logic [AW-1:0]    offset;
  logic [CNT_W-1:0] count, count_next;
  cell_op_t         op;

  logic [SW-1:0]    c_start [MAX_BLOCKS];
  logic [LW-1:0]    c_len   [MAX_BLOCKS];
  logic             c_used  [MAX_BLOCKS];
  logic             c_valid [MAX_BLOCKS];
  logic             c_tok   [MAX_BLOCKS];
  cell_flags_t      c_flags [MAX_BLOCKS];

  cell_flags_t      any;
  logic [SW-1:0]    sel_start;
  logic             res_fire;
  logic [13:0]      res_offset;
  logic [1:0]       res_status;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    logic [SW-1:0] ls, rs;
    logic [LW-1:0] ll, rl;
    logic          lu, lv, lt, ru, rv, rt;
    if (g == 0) begin : g_l0
      assign ls = '0; assign ll = '0; assign lu = 1'b0; assign lv = 1'b0; assign lt = 1'b0;
    end else begin : g_ln
      assign ls = c_start[g-1]; assign ll = c_len[g-1]; assign lu = c_used[g-1];
      assign lv = c_valid[g-1]; assign lt = c_tok[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_r0
      assign rs = '0; assign rl = '0; assign ru = 1'b0; assign rv = 1'b0; assign rt = 1'b0;
    end else begin : g_rn
      assign rs = c_start[g+1]; assign rl = c_len[g+1]; assign ru = c_used[g+1];
      assign rv = c_valid[g+1]; assign rt = c_tok[g+1];
    end
    ffba_cell #(
      .ARENA_BYTES (ARENA_BYTES),
      .HEADER_BYTES(HEADER_BYTES),
      .IDX         (g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .op     (op),
      .size   (size),
      .offset (offset),
      .l_start(ls),
      .l_len  (ll),
      .l_used (lu),
      .l_valid(lv),
      .l_tok  (lt),
      .r_start(rs),
      .r_len  (rl),
      .r_used (ru),
      .r_valid(rv),
      .r_tok  (rt),
      .start  (c_start[g]),
      .len    (c_len[g]),
      .used   (c_used[g]),
      .valid  (c_valid[g]),
      .tok    (c_tok[g]),
      .flags  (c_flags[g])
    );
  end

  always_comb begin
    any       = '0;
    sel_start = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      any       = any | c_flags[k];
      sel_start = sel_start | (c_tok[k] ? c_start[k] : '0);
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    op         = OP_HOLD;
    res_fire   = 1'b0;
    res_offset = '0;
    res_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          op         = OP_TOK_START;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd == CMD_ALLOC && any.fit) begin
          res_fire   = 1'b1;
          res_offset = 14'(sel_start);
          state_next = S_IDLE;
          if (any.split_ok && count != CNT_W'(MAX_BLOCKS)) begin
            op         = OP_ALLOC_SPLIT;
            count_next = count + 1'b1;
          end else begin
            op = OP_ALLOC_WHOLE;
          end
        end else if (cmd == CMD_FREE && any.free_hit) begin
          state_next = S_MERGE_R;
        end else if (!any.valid || c_tok[MAX_BLOCKS-1]) begin
          res_fire   = 1'b1;
          res_status = (cmd == CMD_ALLOC) ? ST_NO_FIT : ST_UNKNOWN;
          state_next = S_IDLE;
        end else begin
          op = OP_TOK_RIGHT;
        end
      end
      S_MERGE_R: begin
        if (any.r_free) begin
          op         = OP_ABSORB_RIGHT;
          count_next = count - 1'b1;
        end else begin
          state_next = S_MERGE_L;
        end
      end
      S_MERGE_L: begin
        if (any.l_free) begin
          op         = OP_ABSORB_LEFT;
          count_next = count - 1'b1;
        end else begin
          op         = OP_RELEASE;
          res_fire   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CNT_W'(1);
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd    <= command;
      size   <= AW'(request_size);
      offset <= AW'(block_offset);
    end
    if (res_fire) begin
      payload_offset <= res_offset;
      status         <= res_status;
    end
  end

endmodule

// ===== design/ffba_checker.sv =====
// port level checks for the first fit block allocator, bound to the top level
// depends on ffba_pkg and the first_fit_block_allocator_unit ports
module ffba_checker import ffba_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [13:0] payload_offset,
  input logic [1:0]  status
);

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done) else $error("result in cycle after accept");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NO_FIT || status == ST_UNKNOWN))
    else $error("bad status code");

  a_fail_offset: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> payload_offset == 14'd0)
    else $error("nonzero offset on failure");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done) else $error("not idle after reset");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .payload_offset(payload_offset),
  .status        (status)
);

// ===== dv/first_fit_block_allocator_checker.sv =====
// checker for the first fit block allocator: predicts each result from a block table
// model and compares it with the done strobe outputs; depends on ffba_pkg
module first_fit_block_allocator_checker import ffba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [14:0] request_size,
  input  logic [13:0] block_offset,
  input  logic        done,
  input  logic [13:0] payload_offset,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARENA  = 16384;
  localparam int HDR    = 32;
  localparam int NBLK   = 64;

  typedef struct packed {
    logic [13:0] offset;
    logic [1:0]  status;
  } alloc_result_t;

  int unsigned blk_start [NBLK];
  int unsigned blk_len [NBLK];
  bit          blk_used [NBLK];
  int unsigned blk_count;
  alloc_result_t expected_results[$];

  task automatic table_reset();
    for (int i = 0; i < NBLK; i++) begin
      blk_start[i] = 0; blk_len[i] = 0; blk_used[i] = 0;
    end
    blk_start[0] = HDR;
    blk_len[0] = ARENA - HDR;
    blk_count = 1;
  endtask

  function automatic alloc_result_t grant_block(int unsigned size);
    alloc_result_t r;
    int unsigned i;
    r = '0;
    for (i = 0; i < blk_count; i++)
      if (!blk_used[i] && blk_len[i] > size + HDR) break;
    if (i >= blk_count) begin
      r.status = ST_NO_FIT;
      return r;
    end
    if (blk_len[i] > size + 2 * HDR && blk_count < NBLK) begin
      for (int unsigned k = blk_count; k > i + 1; k--) begin
        blk_start[k] = blk_start[k-1];
        blk_len[k] = blk_len[k-1];
        blk_used[k] = blk_used[k-1];
      end
      blk_start[i+1] = blk_start[i] + size + HDR;
      blk_len[i+1] = blk_len[i] - HDR - size;
      blk_used[i+1] = 0;
      blk_len[i] = size;
      blk_count++;
    end
    blk_used[i] = 1;
    r.offset = blk_start[i][13:0];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic alloc_result_t free_block(int unsigned off);
    alloc_result_t r;
    int unsigned i, lo, hi, gap;
    r = '0;
    for (i = 0; i < blk_count; i++)
      if (blk_used[i] && blk_start[i] == off) break;
    if (i >= blk_count) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    lo = i;
    hi = i;
    while (lo > 0 && !blk_used[lo-1]) lo--;
    while (hi + 1 < blk_count && !blk_used[hi+1]) hi++;
    blk_len[lo] = blk_start[hi] + blk_len[hi] - blk_start[lo];
    blk_used[lo] = 0;
    gap = hi - lo;
    if (gap > 0) begin
      for (int unsigned k = lo + 1; k + gap < blk_count; k++) begin
        blk_start[k] = blk_start[k+gap];
        blk_len[k] = blk_len[k+gap];
        blk_used[k] = blk_used[k+gap];
      end
      blk_count -= gap;
    end
    r.status = ST_OK;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst) begin
      table_reset();
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result offset=%0d status=%0d", payload_offset, status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.offset !== payload_offset || exp_r.status !== status) begin
            if (fail_count < 10)
              $display("mismatch: expected offset=%0d status=%0d, got offset=%0d status=%0d",
                       exp_r.offset, exp_r.status, payload_offset, status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (command == CMD_ALLOC) expected_results.push_back(grant_block(request_size));
        else expected_results.push_back(free_block(block_offset));
      end
    end
  end
endmodule

// ===== dv/first_fit_block_allocator_unit_test.sv =====
// testbench top for the first fit block allocator: directed and random allocate and
// free items in bursts; depends on ffba_pkg, the unit and its checker
module first_fit_block_allocator_unit_test;
  import ffba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [14:0] request_size;
  logic [13:0] block_offset;
  logic        done;
  logic [13:0] payload_offset;
  logic [1:0]  status;
  int          fail_count;
  int          pending;
  logic [13:0] live_offsets[$];

  first_fit_block_allocator_unit DUT (.*);
  first_fit_block_allocator_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // remember granted offsets so frees mostly hit live blocks
  always @(posedge clk)
    if (!rst && done && status == ST_OK && payload_offset != 0)
      live_offsets.push_back(payload_offset);

  task automatic issue_item(logic cmd, logic [14:0] size, logic [13:0] off);
    command <= cmd;
    request_size <= size;
    block_offset <= off;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned sel, idx;
    logic [13:0] off;
    sel = $urandom_range(99);
    if (sel < 50) begin
      case ($urandom_range(9))
        0: issue_item(CMD_ALLOC, 15'($urandom), 14'd0);
        1: issue_item(CMD_ALLOC, 15'($urandom_range(16384, 4000)), 14'($urandom));
        default: issue_item(CMD_ALLOC, 15'($urandom_range(400)), 14'($urandom));
      endcase
    end else if (sel < 92 && live_offsets.size() > 0) begin
      idx = $urandom_range(live_offsets.size() - 1);
      off = live_offsets[idx];
      live_offsets.delete(idx);
      issue_item(CMD_FREE, 15'($urandom), off);
    end else begin
      issue_item(CMD_FREE, 15'($urandom), 14'($urandom));
    end
  endtask

  initial begin
    int unsigned burst;
    rst = 1;
    start = 0;
    command = 0;
    request_size = 0;
    block_offset = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: zero size, unknown offsets, table full, no fit, merges
    issue_item(CMD_ALLOC, 15'd0, 14'd0);
    issue_item(CMD_FREE, 15'd0, 14'd0);
    issue_item(CMD_FREE, 15'h7fff, 14'h3fff);
    issue_item(CMD_ALLOC, 15'h7fff, 14'h3fff);
    issue_item(CMD_ALLOC, 15'd16384, 14'd0);
    issue_item(CMD_ALLOC, 15'd16320, 14'd0);
    issue_item(CMD_ALLOC, 15'd100, 14'd0);
    issue_item(CMD_FREE, 15'd0, 14'd32);
    issue_item(CMD_FREE, 15'd0, 14'd64);
    issue_item(CMD_FREE, 15'd0, 14'd32);
    for (int i = 0; i < 66; i++) issue_item(CMD_ALLOC, 15'd1, 14'd0);
    issue_item(CMD_ALLOC, 15'd16000, 14'd0);
    issue_item(CMD_FREE, 15'd0, 14'd97);
    issue_item(CMD_FREE, 15'd0, 14'd32);
    start <= 0;
    do @(posedge clk); while (pending != 0);
    live_offsets.delete();
    for (int i = 0; i < 66; i++)
      issue_item(CMD_FREE, 15'd0, 14'(32 + 33 * i));
    issue_item(CMD_FREE, 15'd0, 14'(32 + 33 * 63 + 33));
    // random part in bursts
    for (int n = 0; n < 2000; ) begin
      burst = $urandom_range(30, 1);
      for (int b = 0; b < burst; b++) begin
        random_item();
        n++;
      end
      if ($urandom_range(3) != 0) begin
        start <= 0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
    start <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== first_fit_block_allocator_unit.f =====
design/ffba_pkg.sv
design/ffba_cell.sv
design/first_fit_block_allocator_unit.sv
design/ffba_checker.sv
dv/first_fit_block_allocator_checker.sv
dv/first_fit_block_allocator_unit_test.sv
